// ===== hdl/nccc_pkg.sv =====
// ============================================================================
// nccc_pkg
// Shared widths, register indexes, reset values and the queue entry type of
// the next-combination unit.
// ============================================================================
`default_nettype none

package nccc_pkg;

    // Field widths of the stream payloads.
    localparam int ELEM_W      = 8;
    localparam int COUNT_W     = 6;
    localparam int COMBO_W     = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_PAD_W   = 2;
    localparam int OUT_TDATA_W = ELEM_W + COUNT_W + OUT_PAD_W;

    // Width of a stored position; MAX_K must not exceed 64 (not enforced).
    localparam int IDX_W = 6;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_SIZE = 1'b1;

    localparam logic [ELEM_W-1:0]  SET_SIZE_RST   = 8'd8;
    localparam logic [COMBO_W-1:0] COMBO_SIZE_RST = 6'd4;

    // Depth of the queue between front and back; must be a power of two.
    localparam int QDEPTH = 2;

    // One loaded element as it travels from the front to the back.
    typedef struct packed {
        logic [ELEM_W-1:0] elem;
        logic [IDX_W-1:0]  idx;
        logic              close;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== hdl/nccc_front.sv =====
// ============================================================================
// nccc_front
// Accepts elements, tracks the load position and decides where a set closes.
// ============================================================================
`default_nettype none

module nccc_front #(
    parameter int MAX_K = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [nccc_pkg::COMBO_W-1:0]   combo_size,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [nccc_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] element
    input  wire logic                           s_tlast,
    input  wire logic                           q_full,
    output logic                                q_push,
    output nccc_pkg::q_entry_t                  q_entry
);
    import nccc_pkg::*;

    localparam int IW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW  = $clog2(MAX_K + 1);
    localparam int KXW = ((CW > COMBO_W) ? CW : COMBO_W) + 1;

    logic [IW-1:0]  load_idx_reg;
    logic [IW-1:0]  load_idx_next;
    logic [KXW-1:0] k_ext;
    logic [KXW-1:0] m_ext;
    logic           close;

    // The length limit is sampled at every element, so it follows the
    // current register value.
    always_comb begin
        if (combo_size == '0) begin
            k_ext = KXW'(1);
        end else if (KXW'(combo_size) > KXW'(MAX_K)) begin
            k_ext = KXW'(MAX_K);
        end else begin
            k_ext = KXW'(combo_size);
        end
        m_ext = KXW'(load_idx_reg) + KXW'(1);
        close = s_tlast || (m_ext >= k_ext) || (m_ext >= KXW'(MAX_K));
    end

    assign s_tready      = !q_full;
    assign q_push        = s_tvalid && !q_full;
    assign q_entry.elem  = s_tdata[ELEM_W-1:0];
    assign q_entry.idx   = IDX_W'(load_idx_reg);
    assign q_entry.close = close;
    assign load_idx_next = close ? '0 : load_idx_reg + IW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_idx_reg <= '0;
        end else if (q_push) begin
            load_idx_reg <= load_idx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nccc_fifo.sv =====
// ============================================================================
// nccc_fifo
// Short queue of loaded elements between the front and the back.
// ============================================================================
`default_nettype none

module nccc_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire nccc_pkg::q_entry_t push_entry,
    output logic                    full,
    input  wire logic               pop,
    output nccc_pkg::q_entry_t      pop_entry,
    output logic                    valid
);
    import nccc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    q_entry_t      slot_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;

    assign full      = (cnt_reg == (PW+1)'(QDEPTH));
    assign valid     = (cnt_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (PW+1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nccc_back.sv =====
// ============================================================================
// nccc_back
// Stores a set, finds the pivot, forms the successor, counts the missing
// elements and streams the result out through an output register.
// ============================================================================
`default_nettype none

module nccc_back #(
    parameter int MAX_K = 32,
    parameter int MAX_N = 255
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [nccc_pkg::ELEM_W-1:0]      set_size,
    input  wire logic                             q_valid,
    input  wire nccc_pkg::q_entry_t               q_entry,
    output logic                                  q_ready,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [nccc_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [7:0] element_res,
                                                            // [13:8] new_count
    output logic                                  m_tlast,
    output logic                                  m_tuser   // [0] wrapped
);
    import nccc_pkg::*;

    localparam int IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int TW = ((CW > ELEM_W) ? CW : ELEM_W) + 2;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_CNT_RD,
        S_CNT_CMP,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic [ELEM_W-1:0]  orig_mem [MAX_K];
    logic [ELEM_W-1:0]  rd_data_reg;
    logic [IW-1:0]      rd_addr;
    logic [ELEM_W-1:0]  comb_reg [MAX_K];
    logic [ELEM_W-1:0]  comb_next [MAX_K];
    logic [CW-1:0]      m_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      emit_cnt_reg;
    logic [IW-1:0]      pos_reg;
    logic [IW-1:0]      cnt_idx_reg;
    logic               wrap_reg;
    logic               out_valid_reg;
    logic [ELEM_W-1:0]  out_elem_reg;
    logic               out_last_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_wrap_reg;

    logic [ELEM_W-1:0]  n_eff;
    logic [TW-1:0]      target;
    logic               hit;
    logic               found;
    logic [IW-1:0]      ld_idx;
    logic [CW-1:0]      ld_m;
    logic               out_ready;
    logic               emit_last;
    logic               cnt_last;
    logic [ELEM_W-1:0]  base;

    always_comb begin
        if (int'(set_size) > MAX_N) begin
            n_eff = ELEM_W'(MAX_N);
        end else begin
            n_eff = set_size;
        end
        // Largest allowed value at the current position, n - m + 1 + pos.
        // Negative values land far above any element in TW bits.
        target = TW'(n_eff) + TW'(pos_reg) + TW'(1) - TW'(m_reg);
        hit    = (target == TW'(rd_data_reg));
    end

    assign ld_idx    = q_entry.idx[IW-1:0];
    assign ld_m      = CW'(ld_idx) + CW'(1);
    assign q_ready   = (state_reg == S_LOAD);
    assign rd_addr   = (state_reg == S_CNT_RD) ? cnt_idx_reg : pos_reg;
    assign out_ready = !out_valid_reg || m_tready;
    assign emit_last = (emit_cnt_reg == m_reg - CW'(1));
    assign cnt_last  = (CW'(cnt_idx_reg) == m_reg - CW'(1));
    assign base      = rd_data_reg + ELEM_W'(1);

    // Successor: the pivot gets one more, the tail counts up from it.
    always_comb begin
        for (int j = 0; j < MAX_K; j++) begin
            if (IW'(j) >= pos_reg) begin
                comb_next[j] = base + ELEM_W'(IW'(j) - pos_reg);
            end else begin
                comb_next[j] = comb_reg[j];
            end
        end
    end

    // One old element against every element of the new set.
    always_comb begin
        found = 1'b0;
        for (int j = 0; j < MAX_K; j++) begin
            if ((CW'(j) < m_reg) && (comb_reg[j] == rd_data_reg)) begin
                found = 1'b1;
            end
        end
    end

    // Copy of the set as loaded, read one position per access.
    always_ff @(posedge aclk) begin
        if (q_ready && q_valid) begin
            orig_mem[ld_idx] <= q_entry.elem;
        end
        rd_data_reg <= orig_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            out_valid_reg <= 1'b0;
        end else begin
            // The output register refills while emitting, otherwise it empties
            // once the downstream side takes its transaction.
            if (state_reg == S_EMIT && out_ready) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (q_valid) begin
                        comb_reg[ld_idx] <= q_entry.elem;
                        if (q_entry.close) begin
                            m_reg     <= ld_m;
                            pos_reg   <= ld_idx;
                            state_reg <= S_SRCH_RD;
                        end
                    end
                end
                S_SRCH_RD: begin
                    state_reg <= S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    if (hit) begin
                        if (pos_reg == '0) begin
                            wrap_reg     <= 1'b1;
                            count_reg    <= m_reg;
                            emit_cnt_reg <= '0;
                            state_reg    <= S_EMIT;
                        end else begin
                            pos_reg   <= pos_reg - IW'(1);
                            state_reg <= S_SRCH_RD;
                        end
                    end else begin
                        for (int j = 0; j < MAX_K; j++) begin
                            comb_reg[j] <= comb_next[j];
                        end
                        wrap_reg    <= 1'b0;
                        count_reg   <= '0;
                        cnt_idx_reg <= '0;
                        state_reg   <= S_CNT_RD;
                    end
                end
                S_CNT_RD: begin
                    state_reg <= S_CNT_CMP;
                end
                S_CNT_CMP: begin
                    if (!found) begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (cnt_last) begin
                        emit_cnt_reg <= '0;
                        state_reg    <= S_EMIT;
                    end else begin
                        cnt_idx_reg <= cnt_idx_reg + IW'(1);
                        state_reg   <= S_CNT_RD;
                    end
                end
                S_EMIT: begin
                    if (out_ready) begin
                        out_elem_reg  <= comb_reg[0];
                        out_last_reg  <= emit_last;
                        out_count_reg <= emit_last ? COUNT_W'(count_reg) : '0;
                        out_wrap_reg  <= wrap_reg;
                        for (int j = 0; j < MAX_K - 1; j++) begin
                            comb_reg[j] <= comb_reg[j+1];
                        end
                        emit_cnt_reg <= emit_cnt_reg + CW'(1);
                        if (emit_last) begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_count_reg, out_elem_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_wrap_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (count_reg <= m_reg))
        else $error("missing count exceeds set length");

    a_pivot_in_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SRCH_RD || state_reg == S_SRCH_CMP) |-> (CW'(pos_reg) < m_reg))
        else $error("pivot search left the loaded set");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_ready && emit_last)
        |=> (state_reg == S_LOAD && m_tvalid && m_tlast))
        else $error("final result did not end the set");

endmodule

`default_nettype wire

// ===== hdl/next_combination_with_change_count_unit.sv =====
// ============================================================================
// next_combination_with_change_count_unit
// Lexicographic successor of a loaded k-combination with a changed-element count.
// ============================================================================
// Throughput: elements load at one per cycle while the queue has room; a set
//   of m elements then goes through the pivot search (a read and a compare per
//   position scanned), the membership count (skipped on wrap) and the output.
// The count reads one stored element at a time, in a read state and then a
//   compare state.
// Reset: aresetn is synchronous and active low; there is no clearing pass.
`default_nettype none

module next_combination_with_change_count_unit #(
    parameter int MAX_K = 32,
    parameter int MAX_N = 255
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration writes.
    input  wire logic                              cfg_wr_en,
    input  wire logic [nccc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [nccc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input elements.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [nccc_pkg::IN_TDATA_W-1:0]   s_tdata,  // [7:0] element
    input  wire logic                              s_tlast,  // last
    // Results.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [nccc_pkg::OUT_TDATA_W-1:0]       m_tdata,  // [7:0] element_res,
                                                             // [13:8] new_count
    output logic                                   m_tlast,  // last_res
    output logic                                   m_tuser   // [0] wrapped
);
    import nccc_pkg::*;

    // The front side classifies every incoming transaction: it tracks the
    // load position and decides, with the current combo_size, whether the
    // element closes its set. Elements then wait in a short queue, so while the
    // back is still busy the front takes the next set until the queue is full.

    logic [ELEM_W-1:0]  set_size_reg;
    logic [COMBO_W-1:0] combo_size_reg;

    logic     q_full;
    logic     q_push;
    q_entry_t q_in;
    logic     q_valid;
    logic     q_pop_ready;
    q_entry_t q_out;

    // Configuration registers; write only while the unit is idle, not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg   <= SET_SIZE_RST;
            combo_size_reg <= COMBO_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SET_SIZE:   set_size_reg   <= cfg_wdata[ELEM_W-1:0];
                REG_COMBO_SIZE: combo_size_reg <= cfg_wdata[COMBO_W-1:0];
            endcase
        end
    end

    nccc_front #(
        .MAX_K (MAX_K)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .combo_size (combo_size_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    nccc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_valid && q_pop_ready),
        .pop_entry  (q_out),
        .valid      (q_valid)
    );

    // The back side stores the set, walks down from the last position to the
    // pivot, rewrites the tail, counts old elements that vanished, and streams
    // the set out through its output register.
    nccc_back #(
        .MAX_K (MAX_K),
        .MAX_N (MAX_N)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .set_size (set_size_reg),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_ready  (q_pop_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_next_combination_with_change_count_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_next_combination_with_change_count_unit
// Streams k-combinations into the successor unit and checks every returned
// element, last mark, changed-element count and wrap flag against an
// in-bench predictor. It runs directed corner cases first and then random
// traffic over several ground-set and combination sizes, with random idle
// gaps on the input side and random back-pressure on the result side.
// ============================================================================

module tb_next_combination_with_change_count_unit;

    import nccc_pkg::*;

    localparam int MAX_K        = 32;
    localparam int MAX_N        = 255;
    // The longest set (32 elements) passes the pivot search and count before its
    // first result. This pause covers it with margin before any register write.
    localparam int DRAIN_CYCLES = 300;

    // One element of a successor combination as it leaves the block.
    typedef struct packed {
        logic [ELEM_W-1:0]  elem;
        logic [COUNT_W-1:0] count;
        logic               last;
        logic               wrapped;
    } successor_t;

    // ------------------------------------------------------------------------
    // Clock, DUT ports and the instance.
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [7:0] element
    logic                   s_tlast;   // last
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [7:0] element_res, [13:8] new_count
    logic                   m_tlast;   // last_res
    logic                   m_tuser;   // [0] wrapped

    always #4 aclk = ~aclk;

    next_combination_with_change_count_unit #(
        .MAX_K(MAX_K),
        .MAX_N(MAX_N)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Predictor state. This mirrors the block: the working set that gets
    // advanced, the set exactly as it was loaded, the load position and the
    // two configuration registers.
    // ------------------------------------------------------------------------
    logic [ELEM_W-1:0]  work_set   [MAX_K];
    logic [ELEM_W-1:0]  loaded_set [MAX_K];
    int                 load_pos;
    logic [ELEM_W-1:0]  ground_reg;
    logic [COMBO_W-1:0] combo_reg;

    successor_t pending_successors[$];
    int         mismatch_count;
    int         items_sent;

    // Idle controls: when off, that side of the block runs back to back.
    bit gaps_on;
    bit stalls_on;
    int stall_left = 0;

    // Scratch set that the stimulus tasks build before sending it.
    logic [ELEM_W-1:0] draft_set [MAX_K];

    // A combo_size of zero behaves as one, and anything above MAX_K as MAX_K.
    function automatic int effective_combo(input logic [COMBO_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (int'(raw) > MAX_K)
            return MAX_K;
        return int'(raw);
    endfunction

    // Mostly short idle stretches, with the occasional long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 93)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Takes one accepted element. When it closes the set, the successor is
    // formed and its elements are queued as expected results.
    task automatic advance_combination(input logic [ELEM_W-1:0] elem,
                                       input logic last_flag);
        int         len;
        int         ground;
        int         pivot;
        int         missing;
        bit         wrap;
        bit         found;
        successor_t item;
        if (load_pos >= MAX_K)
            load_pos = MAX_K - 1;
        work_set[load_pos]   = elem;
        loaded_set[load_pos] = elem;
        len = load_pos + 1;
        // The close test uses the combination size in force right now, so a
        // size that shrank during a load closes the set on the next element.
        if (!last_flag && len < effective_combo(combo_reg) && len < MAX_K) begin
            load_pos = len;
            return;
        end
        load_pos = 0;
        ground = (int'(ground_reg) > MAX_N) ? MAX_N : int'(ground_reg);

        // Rightmost position still below its largest allowed value. With a
        // tiny ground set that limit can drop below zero and then nothing
        // matches it, so the search stops there.
        pivot = len - 1;
        while (pivot >= 0 && int'(work_set[pivot]) == ground - len + 1 + pivot)
            pivot--;

        if (pivot < 0) begin
            wrap    = 1'b1;
            missing = len;
        end else begin
            wrap = 1'b0;
            // Increment and refill wrap at eight bits like the stored registers.
            work_set[pivot] = work_set[pivot] + 8'd1;
            for (int j = pivot + 1; j < len; j++)
                work_set[j] = work_set[j - 1] + 8'd1;
            missing = 0;
            for (int i = 0; i < len; i++) begin
                found = 1'b0;
                for (int j = 0; j < len; j++)
                    if (work_set[j] == loaded_set[i])
                        found = 1'b1;
                if (!found)
                    missing++;
            end
        end

        for (int j = 0; j < len; j++) begin
            item.elem    = work_set[j];
            item.last    = (j == len - 1);
            item.count   = (j == len - 1) ? COUNT_W'(missing) : '0;
            item.wrapped = wrap;
            pending_successors.push_back(item);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driving. Inputs change on the falling edge; a transaction counts at the
    // rising edge where tvalid and tready are both high.
    // ------------------------------------------------------------------------
    task automatic send_element(input logic [ELEM_W-1:0] elem, input logic last_flag);
        int gap;
        gap = (gaps_on && $urandom_range(0, 99) < 35) ? idle_length() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        s_tlast  <= last_flag;
        do
            @(posedge aclk);
        while (!s_tready);
        items_sent++;
        advance_combination(elem, last_flag);
    endtask

    // Drops tvalid, lets every expected result drain and then gives the block
    // time to finish any set that produced nothing yet.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_successors.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        if (index == REG_SET_SIZE)
            ground_reg = value[ELEM_W-1:0];
        else
            combo_reg = value[COMBO_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] ground,
                             input logic [CFG_DATA_W-1:0] combo);
        wait_idle();
        write_reg(REG_SET_SIZE, ground);
        write_reg(REG_COMBO_SIZE, combo);
    endtask

    // Random sorted subset of 1..hi with cnt members, written from slot 0.
    task automatic pick_subset(input int hi, input int cnt);
        int need;
        int slot;
        need = cnt;
        slot = 0;
        for (int v = 1; v <= hi && need > 0; v++)
            if ($urandom_range(0, hi - v) < need) begin
                draft_set[slot] = ELEM_W'(v);
                slot++;
                need--;
            end
    endtask

    // A set whose tail already sits at its maxima, so the pivot lands at a
    // random depth and the final combination comes up now and then.
    task automatic pick_tail_set(input int ground, input int size);
        int fixed;
        fixed = $urandom_range(0, size);
        pick_subset(ground - size + fixed, fixed);
        for (int i = fixed; i < size; i++)
            draft_set[i] = ELEM_W'(ground - size + 1 + i);
    endtask

    // Sends the first len draft elements. Without a last mark the set has to
    // close on the element count instead.
    task automatic send_draft(input int len, input bit mark_last);
        for (int i = 0; i < len; i++)
            send_element(draft_set[i], mark_last && (i == len - 1));
    endtask

    // ------------------------------------------------------------------------
    // Result checking: every result transaction is compared with the oldest
    // expectation.
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    always @(posedge aclk) begin
        successor_t seen;
        successor_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.elem    = m_tdata[ELEM_W-1:0];
            seen.count   = m_tdata[ELEM_W +: COUNT_W];
            seen.last    = m_tlast;
            seen.wrapped = m_tuser;
            if (pending_successors.size() == 0) begin
                note_mismatch($sformatf(
                    "unexpected result elem=%0d last=%0d count=%0d wrap=%0d",
                    seen.elem, seen.last, seen.count, seen.wrapped));
            end else begin
                want = pending_successors.pop_front();
                if (seen.elem != want.elem || seen.last != want.last ||
                    seen.count != want.count || seen.wrapped != want.wrapped)
                    note_mismatch({
                        $sformatf("expected elem=%0d last=%0d count=%0d wrap=%0d",
                                  want.elem, want.last, want.count, want.wrapped),
                        $sformatf(", got elem=%0d last=%0d count=%0d wrap=%0d",
                                  seen.elem, seen.last, seen.count, seen.wrapped)});
            end
        end
    end

    // Result side back-pressure: random stalls of random length, or none at
    // all while stalls are switched off.
    always @(negedge aclk) begin
        if (!stalls_on) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left = idle_length() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Reset values n = 8, k = 4: the first combination steps to its successor.
    task automatic test_reset_defaults();
        send_element(8'd1, 1'b0);
        send_element(8'd2, 1'b0);
        send_element(8'd3, 1'b0);
        send_element(8'd4, 1'b1);
    endtask

    // The final combination has no successor and comes back flagged as
    // wrapped; it closes on the count here, with no last mark.
    task automatic test_final_combination();
        send_element(8'd5, 1'b0);
        send_element(8'd6, 1'b0);
        send_element(8'd7, 1'b0);
        send_element(8'd8, 1'b0);
    endtask

    // A last mark before k elements closes a shorter set.
    task automatic test_early_last();
        send_element(8'd2, 1'b0);
        send_element(8'd7, 1'b1);
    endtask

    // combo_size of zero acts as one. With n = 255 the largest element wraps,
    // and the out-of-range zero simply steps to one.
    task automatic test_single_element();
        configure(8'd255, 8'd0);
        send_element(8'd255, 1'b0);
        send_element(8'd0, 1'b0);
        send_element(8'd128, 1'b1);
    endtask

    // n = 1 with k = 3 pushes the allowed maxima below one, and the elements
    // arrive out of order.
    task automatic test_small_ground_set();
        configure(8'd1, 8'd3);
        send_element(8'd9, 1'b0);
        send_element(8'd3, 1'b0);
        send_element(8'd1, 1'b1);
    endtask

    // The pivot holds 255 while below its maximum, so the increment and the
    // refill wrap through zero.
    task automatic test_byte_wrap();
        configure(8'd255, 8'd2);
        send_element(8'd255, 1'b0);
        send_element(8'd255, 1'b0);
    endtask

    // k shrinks below the number already loaded; the next element closes.
    task automatic test_midload_resize();
        configure(8'd20, 8'd8);
        send_element(8'd4, 1'b0);
        send_element(8'd9, 1'b0);
        send_element(8'd15, 1'b0);
        wait_idle();
        write_reg(REG_COMBO_SIZE, 8'd2);
        send_element(8'd17, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: per setting, mostly well-formed sets with random content
    // (uniform or with a maximal tail), plus noise and truncated sets.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        int unsigned phase_ground [8] = '{8, 255, 10, 6, 20, 255, 3, 50};
        int unsigned phase_combo  [8] = '{4, 255, 3, 6, 1, 5, 7, 12};
        int          phase_goal   [8] = '{25, 50, 25, 20, 20, 25, 20, 25};
        int          start;
        int          ground;
        int          size;
        int          roll;
        for (int p = 0; p < 8; p++) begin
            configure(CFG_DATA_W'(phase_ground[p]), CFG_DATA_W'(phase_combo[p]));
            // Some settings run with no idling at all on either side.
            gaps_on   = (p % 3 != 2);
            stalls_on = (p % 3 != 2);
            ground = int'(ground_reg);
            size   = effective_combo(combo_reg);
            start  = items_sent;
            while (items_sent - start < phase_goal[p]) begin
                roll = $urandom_range(0, 99);
                if (size <= ground && roll < 45) begin
                    pick_subset(ground, size);
                    send_draft(size, $urandom_range(0, 3) != 0);
                end else if (size <= ground && roll < 75) begin
                    pick_tail_set(ground, size);
                    send_draft(size, $urandom_range(0, 3) != 0);
                end else if (size <= ground && roll < 87) begin
                    // Truncated set: a valid prefix closed early by the last mark.
                    pick_subset(ground, size);
                    send_draft($urandom_range(1, size), 1'b1);
                end else begin
                    // Noise: arbitrary bytes, possibly left open to run into
                    // the next set.
                    roll = $urandom_range(1, size);
                    for (int i = 0; i < roll; i++)
                        draft_set[i] = ELEM_W'($urandom_range(0, 255));
                    send_draft(roll, $urandom_range(0, 4) != 0);
                end
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        mismatch_count = 0;
        items_sent     = 0;
        load_pos       = 0;
        ground_reg     = SET_SIZE_RST;
        combo_reg      = COMBO_SIZE_RST;
        for (int i = 0; i < MAX_K; i++) begin
            work_set[i]   = '0;
            loaded_set[i] = '0;
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_final_combination();
        test_early_last();
        test_single_element();
        test_small_ground_set();
        test_byte_wrap();
        test_midload_resize();
        test_random_traffic();

        // Everything sent: wait out the remaining results, then watch a while
        // longer for anything the block should not have produced.
        wait_idle();

        if (mismatch_count == 0 && pending_successors.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run with every stall at its
    // longest.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
